// File: sv/vdh_pkg.sv
// ----------------------------------------------------------------------------
// vdh_pkg
// Shared types, constants and hash helpers for the vertex dedup hash table.
// ----------------------------------------------------------------------------
package vdh_pkg;

    localparam int unsigned TABLE_ENTRIES_DEF = 4096;
    localparam int unsigned INDEX_LIMIT       = 4096;
    localparam int unsigned INDEX_W           = 12;
    localparam int unsigned COUNT_W           = 13;
    localparam int unsigned QUEUE_DEPTH       = 2;

    localparam logic [63:0] FNV_OFFSET = 64'hCBF29CE484222325;

    typedef struct packed {
        logic [31:0] x_bits;
        logic [31:0] y_bits;
        logic [31:0] z_bits;
        logic        new_mesh;
    } t_vtx_in;

    typedef struct packed {
        logic [INDEX_W-1:0] vertex_index;
        logic               is_new;
        logic               table_full;
    } t_vtx_out;

    typedef struct packed {
        t_vtx_in     key;
        logic [63:0] hash;
    } t_qent;

    typedef struct packed {
        logic               valid;
        logic [31:0]        x;
        logic [31:0]        y;
        logic [31:0]        z;
        logic [INDEX_W-1:0] idx;
    } t_slot;

    // h * prime mod 2^64; FNV prime is 2^40 + 0x1B3, 0x1B3 = 256+128+32+16+2+1
    function automatic logic [63:0] mul_prime(input logic [63:0] h);
        return (h << 40) + (h << 8) + (h << 7) + (h << 5) + (h << 4) + (h << 1) + h;
    endfunction

endpackage

// File: sv/vdh_front.sv
// ----------------------------------------------------------------------------
// vdh_front
// Accepts vertices and computes a word-wise FNV-1a 64 key hash in three stages.
// ----------------------------------------------------------------------------
module vdh_front (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_valid,
    output logic            o_stall,
    input  vdh_pkg::t_vtx_in i_data,
    output logic            o_push,
    output vdh_pkg::t_qent  o_ent,
    input  logic            i_full
);

    logic             r_v1, r_v2, r_v3;
    logic [63:0]      r_h1, r_h2, r_h3;
    vdh_pkg::t_vtx_in r_k1, r_k2, r_k3;
    logic             en1, en2, en3;

    assign o_push  = r_v3 && !i_full;
    assign en3     = !r_v3 || o_push;
    assign en2     = !r_v2 || en3;
    assign en1     = !r_v1 || en2;
    assign o_stall = !en1;
    assign o_ent   = '{key: r_k3, hash: r_h3};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
        end else begin
            if (en1) begin
                r_v1 <= i_valid;
                r_k1 <= i_data;
                r_h1 <= vdh_pkg::mul_prime(vdh_pkg::FNV_OFFSET ^ {32'd0, i_data.x_bits});
            end
            if (en2) begin
                r_v2 <= r_v1;
                r_k2 <= r_k1;
                r_h2 <= vdh_pkg::mul_prime(r_h1 ^ {32'd0, r_k1.y_bits});
            end
            if (en3) begin
                r_v3 <= r_v2;
                r_k3 <= r_k2;
                r_h3 <= vdh_pkg::mul_prime(r_h2 ^ {32'd0, r_k2.z_bits});
            end
        end
    end

endmodule

// File: sv/vdh_queue.sv
// ----------------------------------------------------------------------------
// vdh_queue
// Small FIFO of hashed vertices between the hash front and the probe engine.
// ----------------------------------------------------------------------------
module vdh_queue (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_push,
    input  vdh_pkg::t_qent i_ent,
    output logic           o_full,
    input  logic           i_pop,
    output vdh_pkg::t_qent o_ent,
    output logic           o_nonempty
);

    localparam int unsigned PW = (vdh_pkg::QUEUE_DEPTH > 1) ? $clog2(vdh_pkg::QUEUE_DEPTH) : 1;
    localparam int unsigned CW = $clog2(vdh_pkg::QUEUE_DEPTH + 1);

    vdh_pkg::t_qent r_q [vdh_pkg::QUEUE_DEPTH];
    logic [PW-1:0]  r_wp, r_rp;
    logic [CW-1:0]  r_cnt;

    assign o_full     = (r_cnt == CW'(vdh_pkg::QUEUE_DEPTH));
    assign o_nonempty = (r_cnt != '0);
    assign o_ent      = r_q[r_rp];

    function automatic logic [PW-1:0] next_ptr(input logic [PW-1:0] p);
        return (p == PW'(vdh_pkg::QUEUE_DEPTH - 1)) ? '0 : p + 1'b1;
    endfunction

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_q[r_wp] <= i_ent;
                r_wp      <= next_ptr(r_wp);
            end
            if (i_pop) begin
                r_rp <= next_ptr(r_rp);
            end
            if (i_push && !i_pop) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (i_pop && !i_push) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

endmodule

// File: sv/vdh_back.sv
// ----------------------------------------------------------------------------
// vdh_back
// Probe engine: slot memory, linear probing, inserts, clearing and result.
// ----------------------------------------------------------------------------
module vdh_back #(
    parameter int unsigned TABLE_ENTRIES = vdh_pkg::TABLE_ENTRIES_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_qvalid,
    output logic              o_pop,
    input  vdh_pkg::t_qent    i_ent,
    output logic              o_valid,
    input  logic              i_stall,
    output vdh_pkg::t_vtx_out o_data
);

    localparam int unsigned AW  = $clog2(TABLE_ENTRIES);
    localparam int unsigned CAP =
        (TABLE_ENTRIES < vdh_pkg::INDEX_LIMIT) ? TABLE_ENTRIES : vdh_pkg::INDEX_LIMIT;

    typedef enum logic [2:0] {S_CLEAR, S_IDLE, S_READ, S_CMP, S_EMIT} t_state;

    t_state                        r_state;
    logic [AW-1:0]                 r_clr;
    logic                          r_pend;
    vdh_pkg::t_vtx_in              r_key;
    logic [AW-1:0]                 r_slot;
    logic [AW-1:0]                 r_probes;
    logic [vdh_pkg::COUNT_W-1:0]   r_count;
    vdh_pkg::t_vtx_out             r_res;
    logic                          r_ov;
    vdh_pkg::t_vtx_out             r_out;

    vdh_pkg::t_slot                mem [TABLE_ENTRIES];
    vdh_pkg::t_slot                r_rd;

    logic                          rd_en, wr_en, match, room, load;
    logic [AW-1:0]                 wr_addr;
    vdh_pkg::t_slot                wr_data;

    assign match = (r_rd.x == r_key.x_bits) && (r_rd.y == r_key.y_bits) &&
                   (r_rd.z == r_key.z_bits);
    assign room  = (r_count < vdh_pkg::COUNT_W'(CAP));
    assign load  = (r_state == S_EMIT) && (!r_ov || !i_stall);
    assign o_pop = (r_state == S_IDLE) && i_qvalid;
    assign rd_en = (r_state == S_READ);
    assign o_valid = r_ov;
    assign o_data  = r_out;

    always_comb begin
        wr_en   = 1'b0;
        wr_addr = r_slot;
        wr_data = '{valid: 1'b1, x: r_key.x_bits, y: r_key.y_bits, z: r_key.z_bits,
                    idx: r_count[vdh_pkg::INDEX_W-1:0]};
        if (r_state == S_CLEAR) begin
            wr_en   = 1'b1;
            wr_addr = r_clr;
            wr_data = '0;
        end else if (r_state == S_CMP && !r_rd.valid && room) begin
            wr_en = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            r_rd <= mem[r_slot];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
            r_clr   <= '0;
            r_pend  <= 1'b0;
            r_count <= '0;
            r_ov    <= 1'b0;
        end else begin
            if (load) begin
                r_ov  <= 1'b1;
                r_out <= r_res;
            end else if (!i_stall) begin
                r_ov <= 1'b0;
            end
            unique case (r_state)
                S_CLEAR: begin
                    r_clr <= r_clr + 1'b1;
                    if (r_clr == '1) begin
                        r_count <= '0;
                        r_pend  <= 1'b0;
                        r_state <= r_pend ? S_READ : S_IDLE;
                    end
                end
                S_IDLE: begin
                    if (i_qvalid) begin
                        r_key    <= i_ent.key;
                        r_slot   <= i_ent.hash[AW-1:0];
                        r_probes <= '0;
                        if (i_ent.key.new_mesh) begin
                            r_clr   <= '0;
                            r_pend  <= 1'b1;
                            r_state <= S_CLEAR;
                        end else begin
                            r_state <= S_READ;
                        end
                    end
                end
                S_READ: begin
                    r_state <= S_CMP;
                end
                S_CMP: begin
                    if (!r_rd.valid) begin
                        if (room) begin
                            r_res   <= '{vertex_index: r_count[vdh_pkg::INDEX_W-1:0],
                                         is_new: 1'b1, table_full: 1'b0};
                            r_count <= r_count + 1'b1;
                        end else begin
                            r_res <= '{vertex_index: '0, is_new: 1'b0, table_full: 1'b1};
                        end
                        r_state <= S_EMIT;
                    end else if (match) begin
                        r_res   <= '{vertex_index: r_rd.idx, is_new: 1'b0, table_full: 1'b0};
                        r_state <= S_EMIT;
                    end else if (r_probes == '1) begin
                        r_res   <= '{vertex_index: '0, is_new: 1'b0, table_full: 1'b1};
                        r_state <= S_EMIT;
                    end else begin
                        r_slot   <= r_slot + 1'b1;
                        r_probes <= r_probes + 1'b1;
                        r_state  <= S_READ;
                    end
                end
                S_EMIT: begin
                    if (load) begin
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

endmodule

// File: sv/vertex_dedup_hash_table.sv
// ----------------------------------------------------------------------------
// vertex_dedup_hash_table
// Vertex welding: maps each vertex bit pattern to its first-appearance index.
// ----------------------------------------------------------------------------
// A three-stage word-wise FNV-1a 64 hash front feeds a two-entry queue; the
// probe engine behind it walks the open-addressed slot memory with linear
// probing. The engine takes a transaction from the queue, then runs each
// probe as a registered memory read followed by a compare, and finally
// loads the result into the output register, waiting while that register
// holds a stalled result. After reset, and for a transaction with new_mesh
// set, the engine runs a clearing pass that writes every slot of the slot
// memory before the lookup. TABLE_ENTRIES must be a power of two; the home
// slot is the low bits of the hash.
module vertex_dedup_hash_table #(
    parameter int unsigned TABLE_ENTRIES = vdh_pkg::TABLE_ENTRIES_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    output logic              o_stall,
    input  vdh_pkg::t_vtx_in  i_data,
    output logic              o_valid,
    input  logic              i_stall,
    output vdh_pkg::t_vtx_out o_data
);

    logic           q_push, q_full, q_pop, q_nonempty;
    vdh_pkg::t_qent q_in, q_out;

    vdh_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_stall (o_stall),
        .i_data  (i_data),
        .o_push  (q_push),
        .o_ent   (q_in),
        .i_full  (q_full)
    );

    vdh_queue u_queue (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_push     (q_push),
        .i_ent      (q_in),
        .o_full     (q_full),
        .i_pop      (q_pop),
        .o_ent      (q_out),
        .o_nonempty (q_nonempty)
    );

    vdh_back #(
        .TABLE_ENTRIES (TABLE_ENTRIES)
    ) u_back (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_qvalid (q_nonempty),
        .o_pop    (q_pop),
        .i_ent    (q_out),
        .o_valid  (o_valid),
        .i_stall  (i_stall),
        .o_data   (o_data)
    );

`ifndef SYNTH
    a_push_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        q_push |-> !q_full) else $error("queue push while full");

    a_pop_data: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        q_pop |-> q_nonempty) else $error("queue pop while empty");

    a_full_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_data.table_full) |-> (!o_data.is_new && o_data.vertex_index == '0))
        else $error("full result carries index or new flag");
`endif

endmodule
